### sv/agx_pkg.sv
// Shared constants, tables and helper functions of the AgX tone mapper.
package agx_pkg;

  // Pipeline depth of one channel's curve unit, in cycles.
  localparam int unsigned CURVE_LAT = 87;

  // Inset matrix, Q30, row major (sRGB to Rec.2020 with AgX inset).
  localparam logic [29:0] INSET_M [9] = '{
    30'd585090657, 30'd401342640, 30'd87386453,
    30'd150796365, 30'd809719016, 30'd113208450,
    30'd95377707,  30'd192067850, 30'd786247450
  };

  // Outset matrix, signed Q30, row major.
  localparam logic signed [31:0] OUTSET_M [9] = '{
    32'sd2109420532, -32'sd918971015,  -32'sd116895168,
    -32'sd321395016, 32'sd1424265996,  -32'sd29081246,
    -32'sd176489159, -32'sd255791760,  32'sd1506100448
  };

  // Sigmoid coefficients of t^1 .. t^6, Q24.
  localparam logic signed [33:0] POLY_C [6] = '{
    34'sd352322, 34'sd67295091, -34'sd430872461,
    34'sd1180428141, -34'sd1254566658, 34'sd454142460
  };

  // log2 clamp window, Q20.
  localparam logic signed [27:0] EV_MIN_Q20 = -28'sd13079865;
  localparam logic signed [27:0] EV_MAX_Q20 = 28'sd4221639;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // floor(x/33) = (x * RECIP33) >> 36 for x < 2^30
  localparam logic [30:0] RECIP33 = 31'd2082408386;
  // floor(x/5) = (x * RECIP5) >> 32 for x < 2^30
  localparam logic [29:0] RECIP5  = 30'd858993460;

  // floor(x/n) = (x * EXP_RECIP[n-1]) >> EXP_SHIFT[n-1] for x < 2^30
  localparam logic [30:0] EXP_RECIP [12] = '{
    31'd1073741825, 31'd1073741825, 31'd1431655766, 31'd1073741825,
    31'd1717986919, 31'd1431655766, 31'd1227133514, 31'd1073741825,
    31'd1908874354, 31'd1717986919, 31'd1561806290, 31'd1431655766
  };
  localparam int unsigned EXP_SHIFT [12] = '{
    30, 31, 32, 32, 33, 33, 33, 33, 34, 34, 34, 34
  };

  // Largest polynomial value kept, just below two in Q24.
  localparam logic [24:0] POLY_MAX = 25'h1FFFFFF;

  // Index of the highest nonzero byte.
  function automatic logic [2:0] top_byte(input logic [63:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[8*i +: 8] != 8'd0) idx = 3'(i);
    end
    return idx;
  endfunction

  // Index of the highest set bit of a byte.
  function automatic logic [2:0] top_bit8(input logic [7:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  // One squaring step of the log2 fraction: {fraction bit, next mantissa}.
  function automatic logic [31:0] sq_step(input logic [30:0] x);
    logic [61:0] p;
    p = 62'(x) * 62'(x);
    return p[61] ? {1'b1, p[61:31]} : {1'b0, p[60:30]};
  endfunction

endpackage

### sv/agx_curve.sv
// Per-channel tone curve: log2, clamp, sigmoid polynomial, power 2.4.
module agx_curve import agx_pkg::*; #(
  parameter int IN_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic [61:0] lin_i,
  output logic [27:0] y_o
);

  localparam logic [7:0] LIN_OFS = 8'(IN_FRAC_BITS + 30);

  // ---- two log2 units: unit 0 on the inset sum, unit 1 on the polynomial
  logic [63:0] lu_in      [2];
  logic        lu_side_in [2];
  logic [63:0] l1_w_q     [2];
  logic [2:0]  l1_b_q     [2];
  logic        l1_s_q     [2];
  logic [30:0] sq_x_q     [2][21];
  logic [5:0]  sq_k_q     [2][21];
  logic [19:0] sq_f_q     [2][21];
  logic        sq_s_q     [2][21];

  // polynomial result, registered
  logic        pz_q;
  logic [24:0] pc_q;

  assign lu_in[0]      = {2'b00, lin_i};
  assign lu_side_in[0] = (lin_i == '0);
  assign lu_in[1]      = {39'd0, pc_q};
  assign lu_side_in[1] = pz_q;

  for (genvar u = 0; u < 2; u++) begin : g_log
    logic [2:0]  byte_idx;
    logic [2:0]  bit_idx;
    logic [63:0] norm;

    assign byte_idx = top_byte(lu_in[u]);
    assign bit_idx  = top_bit8(l1_w_q[u][63:56]);
    assign norm     = l1_w_q[u] << (3'd7 - bit_idx);

    always_ff @(posedge clk_i) begin
      l1_w_q[u]    <= lu_in[u] << {3'd7 - byte_idx, 3'b000};
      l1_b_q[u]    <= byte_idx;
      l1_s_q[u]    <= lu_side_in[u];
      sq_x_q[u][0] <= norm[63:33];
      sq_k_q[u][0] <= {l1_b_q[u], bit_idx};
      sq_f_q[u][0] <= '0;
      sq_s_q[u][0] <= l1_s_q[u];
    end

    for (genvar i = 0; i < 20; i++) begin : g_sq
      logic [31:0] step;
      assign step = sq_step(sq_x_q[u][i]);
      always_ff @(posedge clk_i) begin
        sq_x_q[u][i+1] <= step[30:0];
        sq_f_q[u][i+1] <= {sq_f_q[u][i][18:0], step[31]};
        sq_k_q[u][i+1] <= sq_k_q[u][i];
        sq_s_q[u][i+1] <= sq_s_q[u][i];
      end
    end
  end

  // ---- clamp and normalize to t = (d*32+16)/33, Q24
  logic [7:0]         lg_int;
  logic signed [27:0] lg, lg_c;
  logic [24:0]        ev_d;
  logic [29:0]        t_num;
  logic [60:0]        t_prod_q;
  logic [24:0]        t_q;

  always_comb begin
    lg_int = 8'({2'b00, sq_k_q[0][20]}) - LIN_OFS;
    lg     = $signed({lg_int, sq_f_q[0][20]});
    if (sq_s_q[0][20] || lg < EV_MIN_Q20) lg_c = EV_MIN_Q20;
    else if (lg > EV_MAX_Q20)             lg_c = EV_MAX_Q20;
    else                                  lg_c = lg;
    ev_d  = 25'(lg_c - EV_MIN_Q20);
    t_num = {ev_d, 5'b10000};
  end

  always_ff @(posedge clk_i) begin
    t_prod_q <= 61'(t_num) * 61'(RECIP33);
    t_q      <= t_prod_q[60:36];
  end

  // ---- Horner sigmoid, multiply stage then round/add stage per term; the last term rounds and clamps
  logic [57:0]        hm_q   [6];
  logic               hneg_q [6];
  logic [24:0]        hta_q  [6];
  logic [24:0]        htb_q  [5];
  logic signed [33:0] hacc_q [5];

  for (genvar i = 0; i < 6; i++) begin : g_horner
    logic signed [33:0] a_in;
    logic [24:0]        t_in;
    logic [32:0]        a_mag;
    logic [33:0]        r_mag;
    logic signed [33:0] r_s;

    if (i == 0) begin : g_first
      assign a_in = POLY_C[5];
      assign t_in = t_q;
    end else begin : g_next
      assign a_in = hacc_q[i-1];
      assign t_in = htb_q[i-1];
    end

    assign a_mag = 33'(a_in < 0 ? -a_in : a_in);
    assign r_mag = 34'((hm_q[i] + 58'(1 << 23)) >> 24);
    assign r_s   = hneg_q[i] ? -$signed(r_mag) : $signed(r_mag);

    always_ff @(posedge clk_i) begin
      hm_q[i]   <= 58'(a_mag) * 58'(t_in);
      hneg_q[i] <= (a_in < 0);
      hta_q[i]  <= t_in;
    end

    if (i < 5) begin : g_add
      always_ff @(posedge clk_i) begin
        hacc_q[i] <= r_s + POLY_C[4-i];
        htb_q[i]  <= hta_q[i];
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        pz_q <= (r_s <= 0);
        if (r_s <= 0)                          pc_q <= 25'd1;
        else if (r_s > $signed({9'd0, POLY_MAX})) pc_q <= POLY_MAX;
        else                                   pc_q <= r_s[24:0];
      end
    end
  end

  // ---- exponent e = round(log2(p) * 12/5), split into n and fraction
  logic [7:0]         lp_int;
  logic signed [27:0] lp;
  logic [26:0]        lp_mag;
  logic [30:0]        e_num;
  logic [60:0]        e1_prod_q;
  logic               e1_neg_q, e1_pz_q;
  logic [28:0]        e_quo;
  logic signed [29:0] e_val;
  logic signed [29:0] e_int;
  logic [49:0]        e2_fp_q;
  logic signed [6:0]  e2_n_q;
  logic               e2_pz_q;

  always_comb begin
    lp_int = 8'({2'b00, sq_k_q[1][20]}) - 8'd24;
    lp     = $signed({lp_int, sq_f_q[1][20]});
    lp_mag = 27'(lp < 0 ? -lp : lp);
    e_num  = 31'({lp_mag, 3'b000}) + 31'({lp_mag, 2'b00}) + 31'd2;
    e_quo  = 29'(e1_prod_q >> 32);
    e_val  = e1_neg_q ? -$signed({1'b0, e_quo}) : $signed({1'b0, e_quo});
    e_int  = e_val >>> 20;
  end

  always_ff @(posedge clk_i) begin
    e1_prod_q <= 61'(e_num) * 61'(RECIP5);
    e1_neg_q  <= (lp < 0);
    e1_pz_q   <= sq_s_q[1][20];
    e2_fp_q   <= 50'(e_val[19:0]) * 50'(LN2_Q30);
    e2_n_q    <= 7'(e_int);
    e2_pz_q   <= e1_pz_q;
  end

  // ---- 2^f by Taylor series of exp(f*ln2), Q30
  typedef struct packed {
    logic [29:0]       x;
    logic [29:0]       z;
    logic [31:0]       sum;
    logic signed [6:0] n;
    logic              pz;
  } exp_t;

  exp_t        ex_q   [13];
  exp_t        exa_q  [12];
  logic [60:0] exp_q  [12];

  always_ff @(posedge clk_i) begin
    ex_q[0].z   <= 30'((e2_fp_q + 50'(1 << 19)) >> 20);
    ex_q[0].x   <= 30'((e2_fp_q + 50'(1 << 19)) >> 20);
    ex_q[0].sum <= 32'(1 << 30);
    ex_q[0].n   <= e2_n_q;
    ex_q[0].pz  <= e2_pz_q;
  end

  for (genvar k = 0; k < 12; k++) begin : g_exp
    logic [29:0] term;
    assign term = 30'(exp_q[k] >> EXP_SHIFT[k]);
    always_ff @(posedge clk_i) begin
      exp_q[k]       <= 61'(ex_q[k].x) * 61'(EXP_RECIP[k]);
      exa_q[k]       <= ex_q[k];
      ex_q[k+1].sum  <= exa_q[k].sum + 32'(term);
      ex_q[k+1].x    <= 30'((60'(term) * 60'(exa_q[k].z)) >> 30);
      ex_q[k+1].z    <= exa_q[k].z;
      ex_q[k+1].n    <= exa_q[k].n;
      ex_q[k+1].pz   <= exa_q[k].pz;
    end
  end

  // ---- shift by n with rounding, then round to Q24
  logic [5:0]  sh;
  logic [33:0] y_sh;
  logic [33:0] y_q;
  logic        ypz_q;
  logic [27:0] y_out_q;

  always_comb begin
    sh = 6'(-ex_q[12].n);
    if (ex_q[12].n >= 0)
      y_sh = {2'b00, ex_q[12].sum} << ex_q[12].n[1:0];
    else if (sh >= 6'd40)
      y_sh = '0;
    else
      y_sh = 34'(({32'd0, ex_q[12].sum} + (64'd1 << (sh - 6'd1))) >> sh);
  end

  always_ff @(posedge clk_i) begin
    y_q     <= y_sh;
    ypz_q   <= ex_q[12].pz;
    y_out_q <= ypz_q ? '0 : 28'((y_q + 34'd32) >> 6);
  end

  assign y_o = y_out_q;

endmodule

### sv/agx_tone_mapper.sv
// AgX tone mapper top level: inset matrix, three curve units, outset matrix.
// Throughput: one pixel word per cycle; busy_o is always low since every
// stage advances each cycle and the receiver takes each result as strobed.
// Most of the depth comes from the two 22-stage log2 squaring chains and the
// 24-stage exp2 series in each curve unit.
// Reset clears only the valid pipeline; payload registers are not reset.
module agx_tone_mapper import agx_pkg::*; #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic signed [31:0]         red_in_i,
  input  logic signed [31:0]         green_in_i,
  input  logic signed [31:0]         blue_in_i,
  output logic                       done_o,
  output logic signed [OUT_FRAC_BITS+2:0] red_out_o,
  output logic signed [OUT_FRAC_BITS+2:0] green_out_o,
  output logic signed [OUT_FRAC_BITS+2:0] blue_out_o
);

  localparam int OUT_W     = OUT_FRAC_BITS + 3;
  localparam int RSH       = 54 - OUT_FRAC_BITS;  // Q54 products down to output
  localparam int TOTAL_LAT = int'(CURVE_LAT) + 6;

  // valid bits travel alongside the data
  logic [TOTAL_LAT-1:0] vld_q, vld_d;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[TOTAL_LAT-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // negative channels count as zero
  logic [31:0] chan_in [3];
  logic [30:0] chan_c  [3];

  assign chan_in[0] = red_in_i;
  assign chan_in[1] = green_in_i;
  assign chan_in[2] = blue_in_i;

  // inset: nine products, then row sums (unsigned, IN_FRAC_BITS+30 fraction)
  logic [60:0] ip_q  [9];
  logic [61:0] lin_q [3];
  logic [27:0] y_w   [3];

  for (genvar j = 0; j < 3; j++) begin : g_clamp
    assign chan_c[j] = chan_in[j][31] ? '0 : chan_in[j][30:0];
  end

  for (genvar i = 0; i < 3; i++) begin : g_inset
    for (genvar j = 0; j < 3; j++) begin : g_prod
      always_ff @(posedge clk_i) begin
        ip_q[i*3+j] <= 61'(chan_c[j]) * 61'(INSET_M[i*3+j]);
      end
    end

    always_ff @(posedge clk_i) begin
      lin_q[i] <= 62'(ip_q[i*3]) + 62'(ip_q[i*3+1]) + 62'(ip_q[i*3+2]);
    end

    agx_curve #(
      .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_curve (
      .clk_i(clk_i),
      .lin_i(lin_q[i]),
      .y_o  (y_w[i])
    );
  end

  // outset: products, row sums, round half away from zero, saturate
  logic signed [60:0]    op_q   [9];
  logic signed [62:0]    oacc_q [3];
  logic [32:0]           rmag_q [3];
  logic                  rneg_q [3];
  logic signed [OUT_W-1:0] out_q [3];

  localparam logic signed [33:0] OUT_HI = 34'sd2 ** (OUT_W - 1) - 34'sd1;
  localparam logic signed [33:0] OUT_LO = -(34'sd2 ** (OUT_W - 1));

  for (genvar i = 0; i < 3; i++) begin : g_outset
    logic [62:0]        o_mag;
    logic signed [33:0] o_val;

    for (genvar j = 0; j < 3; j++) begin : g_prod
      always_ff @(posedge clk_i) begin
        op_q[i*3+j] <= 61'(OUTSET_M[i*3+j]) * 61'($signed({1'b0, y_w[j]}));
      end
    end

    assign o_mag = 63'(oacc_q[i] < 0 ? -oacc_q[i] : oacc_q[i]);
    assign o_val = rneg_q[i] ? -$signed({1'b0, rmag_q[i]}) : $signed({1'b0, rmag_q[i]});

    always_ff @(posedge clk_i) begin
      oacc_q[i] <= 63'(op_q[i*3]) + 63'(op_q[i*3+1]) + 63'(op_q[i*3+2]);
      rmag_q[i] <= 33'((o_mag + (63'd1 << (RSH - 1))) >> RSH);
      rneg_q[i] <= (oacc_q[i] < 0);
      if (o_val > OUT_HI)      out_q[i] <= OUT_W'(OUT_HI);
      else if (o_val < OUT_LO) out_q[i] <= OUT_W'(OUT_LO);
      else                     out_q[i] <= OUT_W'(o_val);
    end
  end

  assign done_o      = vld_q[TOTAL_LAT-1];
  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];

endmodule

### sim/agx_tone_checker.sv
// Predicts and checks the tone-mapped output pixels of agx_tone_mapper.
`timescale 1ns / 100ps
module agx_tone_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [31:0] red_in_i,
  input  logic signed [31:0] green_in_i,
  input  logic signed [31:0] blue_in_i,
  input  logic               done_i,
  input  logic signed [18:0] red_out_i,
  input  logic signed [18:0] green_out_i,
  input  logic signed [18:0] blue_out_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 pixels_seen_o
);

  typedef struct packed {
    logic signed [18:0] r;
    logic signed [18:0] g;
    logic signed [18:0] b;
  } rgb_out_t;

  localparam longint EV_LO = -64'sd13079865;
  localparam longint EV_HI = 64'sd4221639;
  localparam longint LN2Q30 = 64'sd744261118;

  longint inset_c [9] = '{585090657, 401342640, 87386453, 150796365, 809719016,
                          113208450, 95377707, 192067850, 786247450};
  longint outset_c [9] = '{2109420532, -918971015, -116895168, -321395016, 1424265996,
                           -29081246, -176489159, -255791760, 1506100448};
  longint sig_c [6] = '{352322, 67295091, -430872461, 1180428141, -1254566658,
                        454142460};

  rgb_out_t expected_px [$];

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint rnd_mul(input longint a, input longint b, input int s);
    longint unsigned m;
    m = longint'(mag(a)) * longint'(mag(b));
    m = (m + (64'd1 << (s - 1))) >> s;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Q20 log2, truncated fraction, by normalize and repeated squaring
  function automatic longint log2_fix(input longint unsigned m);
    int k;
    longint unsigned x;
    longint f;
    k = 63;
    f = 0;
    while (k > 0 && m[k] == 1'b0) k--;
    x = (k >= 30) ? (m >> (k - 30)) : (m << (30 - k));
    for (int i = 0; i < 20; i++) begin
      x = (x * x) >> 30;
      f = f << 1;
      if (x >= (64'd1 << 31)) begin
        f = f | 1;
        x = x >> 1;
      end
    end
    return longint'(k) * 1048576 + f;
  endfunction

  function automatic longint unsigned exp2_fix(input longint unsigned f);
    longint unsigned z, acc, term;
    z = (f * longint'(LN2Q30) + (64'd1 << 19)) >> 20;
    acc = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * z) >> 30) / n;
      acc += term;
    end
    return acc;
  endfunction

  // linear inset sum to display-linear Q24 value
  function automatic longint tone_curve(input longint unsigned lin);
    longint lg, t, acc, p, lp, e, y;
    longint unsigned u, mant;
    int n, s;
    if (lin == 0) lg = EV_LO;
    else lg = log2_fix(lin) - longint'(46) * 1048576;
    if (lg < EV_LO) lg = EV_LO;
    if (lg > EV_HI) lg = EV_HI;
    t = ((lg - EV_LO) * 32 + 16) / 33;
    acc = sig_c[5];
    for (int i = 4; i >= 0; i--) acc = rnd_mul(acc, t, 24) + sig_c[i];
    p = rnd_mul(acc, t, 24);
    if (p <= 0) return 0;
    if (p > (64'sd1 << 25) - 1) p = (64'sd1 << 25) - 1;
    lp = log2_fix(p) - longint'(24) * 1048576;
    e = (mag(lp) * 12 + 2) / 5;
    if (lp < 0) e = -e;
    u = e + longint'(64) * 1048576;
    n = int'(u >> 20) - 64;
    mant = exp2_fix(u & 64'hFFFFF);
    if (n >= 0) y = longint'(mant << n);
    else begin
      s = -n;
      if (s >= 40) y = 0;
      else y = longint'((mant + (64'd1 << (s - 1))) >> s);
    end
    return (y + 32) >>> 6;
  endfunction

  function automatic rgb_out_t tone_map_px(input logic signed [31:0] r,
                                           input logic signed [31:0] g,
                                           input logic signed [31:0] b);
    longint unsigned c [3];
    longint lin [3];
    longint unsigned sum;
    longint acc, v;
    logic signed [18:0] o [3];
    c[0] = r < 0 ? 0 : r;
    c[1] = g < 0 ? 0 : g;
    c[2] = b < 0 ? 0 : b;
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) sum += longint'(inset_c[i*3+j]) * c[j];
      lin[i] = tone_curve(sum);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += outset_c[i*3+j] * lin[j];
      v = mag(acc);
      v = (v + (64'sd1 << 37)) >>> 38;
      if (acc < 0) v = -v;
      if (v > 262143) v = 262143;
      if (v < -262144) v = -262144;
      o[i] = v[18:0];
    end
    return '{r: o[0], g: o[1], b: o[2]};
  endfunction

  int fails = 0;
  int seen = 0;

  always @(posedge clk_i) begin
    rgb_out_t want;
    if (rst_ni && start_i && !busy_i)
      expected_px.push_back(tone_map_px(red_in_i, green_in_i, blue_in_i));
    if (rst_ni && done_i) begin
      seen++;
      if (expected_px.size() == 0) begin
        fails++;
        if (fails <= 10) $display("ERROR: output word with none pending");
      end else begin
        want = expected_px.pop_front();
        if (want.r !== red_out_i || want.g !== green_out_i || want.b !== blue_out_i) begin
          fails++;
          if (fails <= 10)
            $display("ERROR: pixel %0d exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     seen, want.r, want.g, want.b, red_out_i, green_out_i, blue_out_i);
        end
      end
    end
  end

  assign fail_count_o  = fails;
  assign pending_o     = expected_px.size();
  assign pixels_seen_o = seen;

endmodule

### sim/testbench.sv
// Stimulus and verdict for the agx_tone_mapper testbench.
`timescale 1ns / 100ps
module testbench;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] red_in = '0;
  logic signed [31:0] green_in = '0;
  logic signed [31:0] blue_in = '0;
  logic               done;
  logic signed [18:0] red_out, green_out, blue_out;
  int                 fail_count, pending, pixels_seen;
  int                 words_sent = 0;

  always #5 clk = ~clk;

  agx_tone_mapper DUT (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .red_in_i(red_in), .green_in_i(green_in), .blue_in_i(blue_in),
    .done_o(done), .red_out_o(red_out), .green_out_o(green_out), .blue_out_o(blue_out)
  );

  agx_tone_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .red_in_i(red_in), .green_in_i(green_in), .blue_in_i(blue_in),
    .done_i(done), .red_out_i(red_out), .green_out_i(green_out), .blue_out_i(blue_out),
    .fail_count_o(fail_count), .pending_o(pending), .pixels_seen_o(pixels_seen)
  );

  // Random channel: spread over the useful HDR range on a log scale, with
  // some negatives, zeros and raw full-range words so every bit toggles.
  function automatic logic [31:0] rand_chan();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 2) return 32'(-$urandom_range(1, 32'h7FFF_FFFF));
    if (sel < 3) return '0;
    if (sel < 5) return $urandom();
    return 32'($urandom() >> $urandom_range(0, 31));
  endfunction

  // Drive one word, holding start until the block takes it.
  task automatic send_px(input logic [31:0] r, input logic [31:0] g, input logic [31:0] b);
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // Gap after a word; none at all for long back-to-back stretches.
  task automatic idle_gap(input bit burst);
    int n;
    if (burst) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n == 0) return;
    start <= 1'b0;
    red_in <= $urandom();
    repeat (n) @(posedge clk);
  endtask

  logic [31:0] edge_vals [10] = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                  32'h0001_0000, 32'h0000_0010, 32'h0100_0000,
                                  32'h0000_4000, 32'h0010_0000};
  int cycle_count;
  bit burst;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, negatives, all-zero (lower clamp), gray and saturating pixels.
    foreach (edge_vals[i]) begin
      send_px(edge_vals[i], edge_vals[i], edge_vals[i]);
      idle_gap(1'b0);
    end
    send_px(32'h7FFF_FFFF, 32'h0, 32'h0); idle_gap(1'b0);
    send_px(32'h0, 32'h7FFF_FFFF, 32'h0); idle_gap(1'b0);
    send_px(32'h0, 32'h0, 32'h7FFF_FFFF); idle_gap(1'b0);
    send_px(32'h0000_0001, 32'h8000_0000, 32'h0200_0000); idle_gap(1'b0);
    send_px(32'h0000_0100, 32'h0000_0000, 32'hFFFF_0000); idle_gap(1'b0);

    for (int i = 0; i < 1800; i++) begin
      if (i % 200 == 0) burst = ($urandom_range(0, 2) == 0);
      send_px(rand_chan(), rand_chan(), rand_chan());
      idle_gap(burst);
    end
    start <= 1'b0;

    cycle_count = 0;
    while (pending != 0 && cycle_count < 2000) begin
      @(posedge clk);
      cycle_count++;
    end
    repeat (120) @(posedge clk);

    $display("Sent %0d pixel words (edge values, negatives, zeros, random HDR range);",
             words_sent);
    $display("checked %0d output words, %0d still pending.", pixels_seen, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("** agx_tone_mapper: PASSED **");
    end else begin
      $display("** agx_tone_mapper: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout");
    $display("** agx_tone_mapper: FAILED **");
    $finish;
  end

endmodule
